// File: hdl/deqr_pkg.sv
// Shared types and operation codes for the double-ended queue with reverse.
`default_nettype none

package deqr_pkg;

    // Fixed field widths of the request and result items.
    localparam int ITEM_W  = 32;
    localparam int COUNT_W = 5;

    // Request operation codes.
    typedef enum logic [1:0] {
        OP_PUSH_HEAD = 2'd0,
        OP_PUSH_TAIL = 2'd1,
        OP_POP_HEAD  = 2'd2,
        OP_REVERSE   = 2'd3
    } t_op;

    // One request item.
    typedef struct packed {
        t_op                      operation;
        logic signed [ITEM_W-1:0] item_value;
    } t_request;

    // One result item.
    typedef struct packed {
        logic                     ok;
        logic signed [ITEM_W-1:0] popped_value;
        logic [COUNT_W-1:0]       entry_count;
    } t_result;

endpackage

`default_nettype wire

// File: hdl/double_ended_queue_with_reverse_unit.sv
// Top level of the bounded double-ended queue with constant-time reverse.
// Every item gives its result on o_done in the cycle after it is accepted.
// Throughput: one item per cycle; busy is never raised, as the entry memory has one
// write port and one registered read port and each item uses at most one of them.
// A removal reads the head entry in the accepting cycle; the read data is registered.
// Reset clears the front index, the entry count and the direction flag; the entry
// memory is not cleared, and only entries already written are ever read.
`default_nettype none

module double_ended_queue_with_reverse_unit
    import deqr_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     start,
    input  wire t_request i_request,
    output logic          busy,
    output logic          o_done,
    output t_result       o_result
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W:0] DEPTH_V = (IDX_W + 1)'(DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    // Entry memory, written at one address and read at one address per cycle.
    logic signed [ITEM_W-1:0] r_store [DEPTH];
    logic signed [ITEM_W-1:0] r_rd_data;

    // Pointer state.
    logic [IDX_W-1:0] r_front, n_front;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_rev,   n_rev;

    // Result registers.
    logic r_done;
    logic r_ok,  n_ok;
    logic r_pop, n_pop;

    logic             accept;
    logic             full;
    logic             empty;
    logic [IDX_W-1:0] offset;
    logic             step_up;
    logic [IDX_W:0]   sum;
    logic [IDX_W:0]   diff;
    logic [IDX_W-1:0] target;
    logic             we;
    logic             re;

    // The block never holds a request off.
    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (r_count == DEPTH_C);
    assign empty  = (r_count == '0);

    // Ring offset from the front that the operation needs.
    always_comb begin
        unique case (i_request.operation)
            OP_PUSH_TAIL: offset = r_count[IDX_W-1:0];
            OP_REVERSE:   offset = IDX_W'(r_count - CNT_W'(1));
            default:      offset = IDX_W'(1);
        endcase
    end

    // Inserting at the head steps against the direction of order; all else steps with it.
    assign step_up = (i_request.operation == OP_PUSH_HEAD) ? r_rev : !r_rev;

    // Modular step around the ring: one add or subtract and one correction.
    always_comb begin
        sum  = {1'b0, r_front} + {1'b0, offset};
        if (sum >= DEPTH_V) begin
            sum = sum - DEPTH_V;
        end
        if (r_front >= offset) begin
            diff = {1'b0, r_front} - {1'b0, offset};
        end else begin
            diff = {1'b0, r_front} + DEPTH_V - {1'b0, offset};
        end
        target = step_up ? sum[IDX_W-1:0] : diff[IDX_W-1:0];
    end

    // Next pointer state and result flags for the accepted item.
    always_comb begin
        n_front = r_front;
        n_count = r_count;
        n_rev   = r_rev;
        n_ok    = 1'b0;
        n_pop   = 1'b0;
        we      = 1'b0;
        re      = 1'b0;
        if (accept) begin
            unique case (i_request.operation)
                OP_PUSH_HEAD: begin
                    if (!full) begin
                        n_front = target;
                        n_count = r_count + CNT_W'(1);
                        n_ok    = 1'b1;
                        we      = 1'b1;
                    end
                end
                OP_PUSH_TAIL: begin
                    if (!full) begin
                        n_count = r_count + CNT_W'(1);
                        n_ok    = 1'b1;
                        we      = 1'b1;
                    end
                end
                OP_POP_HEAD: begin
                    if (!empty) begin
                        n_front = target;
                        n_count = r_count - CNT_W'(1);
                        n_ok    = 1'b1;
                        n_pop   = 1'b1;
                        re      = 1'b1;
                    end
                end
                OP_REVERSE: begin
                    if (!empty) begin
                        n_front = target;
                    end
                    n_rev = !r_rev;
                    n_ok  = 1'b1;
                end
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
            r_rev   <= 1'b0;
            r_done  <= 1'b0;
            r_ok    <= 1'b0;
            r_pop   <= 1'b0;
        end else begin
            r_front <= n_front;
            r_count <= n_count;
            r_rev   <= n_rev;
            r_done  <= accept;
            r_ok    <= n_ok;
            r_pop   <= n_pop;
        end
    end

    // Entry memory: write the inserted item, read the head entry on a removal.
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_store[target] <= i_request.item_value;
        end
        if (re) begin
            r_rd_data <= r_store[r_front];
        end
    end

    // Result item, shown in the cycle after acceptance.
    assign o_done                = r_done;
    assign o_result.ok           = r_ok;
    assign o_result.popped_value = r_pop ? r_rd_data : '0;
    assign o_result.entry_count  = COUNT_W'(r_count);

    // The count never exceeds the ring size.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("entry count beyond ring size");

    // A result strobe follows every accepted item in the next cycle.
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_done)
        else $error("result strobe missing after accepted item");

    // A failed request never reports a removed value.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_result.ok) |-> (o_result.popped_value == '0))
        else $error("failed request carries a value");

    // Reverse leaves the count unchanged and flips the direction flag.
    a_reverse_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_request.operation == OP_REVERSE)
            |=> (r_count == $past(r_count)) && (r_rev != $past(r_rev)))
        else $error("reverse altered the count or kept the direction");

endmodule

`default_nettype wire

// File: tb/tb_double_ended_queue_with_reverse_unit.sv
// Self-checking testbench for the double-ended queue with constant-time reverse.
`default_nettype none

module tb_double_ended_queue_with_reverse_unit;
    import deqr_pkg::*;

    localparam int QDEPTH = 16;

    // Clock, reset and the ports of the block.
    logic     i_clk     = 1'b0;
    logic     i_rst_n   = 1'b0;
    logic     start     = 1'b0;
    t_request i_request = '0;
    logic     busy;
    logic     o_done;
    t_result  o_result;

    double_ended_queue_with_reverse_unit #(
        .DEPTH(QDEPTH)
    ) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_request(i_request),
        .busy     (busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    // Items waiting to be offered, and results predicted but not yet seen.
    t_request pending_items[$];
    t_result  expected_results[$];

    // Shadow copy of the queue state.
    logic [ITEM_W-1:0] shadow_store [QDEPTH];
    int                shadow_front    = 0;
    int                shadow_count    = 0;
    bit                shadow_reversed = 1'b0;

    // Run statistics.
    int sender_idle_pct = 0;
    int mismatch_count  = 0;
    int results_checked = 0;
    int full_rejects    = 0;
    int empty_rejects   = 0;
    int op_count [4]    = '{0, 0, 0, 0};

    // The clock runs with a period of 20.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Ring address of a logical position, counted from the head.
    function automatic int ring_slot(input int pos);
        int p;
        p = pos % QDEPTH;
        if (shadow_reversed) begin
            return (shadow_front + QDEPTH - p) % QDEPTH;
        end
        return (shadow_front + p) % QDEPTH;
    endfunction

    // Apply one request to the shadow queue and return the result it should give.
    function automatic t_result predict_response(input t_request req);
        t_result r;
        r.ok           = 1'b0;
        r.popped_value = '0;
        op_count[int'(req.operation)]++;
        case (req.operation)
            OP_PUSH_HEAD: begin
                if (shadow_count < QDEPTH) begin
                    if (shadow_reversed) begin
                        shadow_front = (shadow_front + 1) % QDEPTH;
                    end else begin
                        shadow_front = (shadow_front + QDEPTH - 1) % QDEPTH;
                    end
                    shadow_store[shadow_front] = req.item_value;
                    shadow_count++;
                    r.ok = 1'b1;
                end else begin
                    full_rejects++;
                end
            end
            OP_PUSH_TAIL: begin
                if (shadow_count < QDEPTH) begin
                    shadow_store[ring_slot(shadow_count)] = req.item_value;
                    shadow_count++;
                    r.ok = 1'b1;
                end else begin
                    full_rejects++;
                end
            end
            OP_POP_HEAD: begin
                if (shadow_count > 0) begin
                    r.popped_value = shadow_store[shadow_front];
                    shadow_front   = ring_slot(1);
                    shadow_count--;
                    r.ok = 1'b1;
                end else begin
                    empty_rejects++;
                end
            end
            default: begin
                // Reverse: the head moves to the last entry and the direction flips.
                if (shadow_count > 0) begin
                    shadow_front = ring_slot(shadow_count - 1);
                end
                shadow_reversed = !shadow_reversed;
                r.ok = 1'b1;
            end
        endcase
        r.entry_count = COUNT_W'(shadow_count);
        return r;
    endfunction

    // Mostly uniform values, with the corner values now and then.
    function automatic logic [ITEM_W-1:0] random_value();
        case ($urandom_range(15))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_item(input t_op op, input logic [ITEM_W-1:0] value);
        t_request req;
        req.operation  = op;
        req.item_value = value;
        pending_items.push_back(req);
    endtask

    // Directed part: empty and full queues, extreme values and reverse at both ends.
    task automatic queue_directed_items();
        add_item(OP_POP_HEAD, 32'hDEAD_BEEF);
        add_item(OP_REVERSE, 32'h1234_5678);
        add_item(OP_PUSH_HEAD, 32'h7FFF_FFFF);
        add_item(OP_PUSH_TAIL, 32'h8000_0000);
        add_item(OP_PUSH_HEAD, 32'hFFFF_FFFF);
        add_item(OP_PUSH_TAIL, 32'h0000_0000);
        add_item(OP_REVERSE, 32'hFFFF_FFFF);
        add_item(OP_POP_HEAD, 32'h0000_0000);
        add_item(OP_POP_HEAD, 32'h5555_5555);
        for (int k = 0; k < 14; k++) begin
            add_item((k % 2 == 0) ? OP_PUSH_HEAD : OP_PUSH_TAIL,
                     (k % 3 == 0) ? ~(32'h1 << k) : (32'h1 << (31 - k)));
        end
        add_item(OP_PUSH_TAIL, 32'hAAAA_AAAA);
        add_item(OP_REVERSE, 32'h0000_0000);
    endtask

    // Random part in runs: filling, draining, mixed and reverse-heavy stretches.
    task automatic queue_random_items(input int n);
        int left;
        int mode;
        int run;
        int pick;
        t_op op;
        left = n;
        while (left > 0) begin
            mode = $urandom_range(3);
            run  = $urandom_range(40, 8);
            if (run > left) begin
                run = left;
            end
            repeat (run) begin
                pick = $urandom_range(99);
                case (mode)
                    0: op = (pick < 45) ? OP_PUSH_HEAD : (pick < 90) ? OP_PUSH_TAIL :
                            (pick < 95) ? OP_POP_HEAD : OP_REVERSE;
                    1: op = (pick < 15) ? OP_PUSH_HEAD : (pick < 30) ? OP_PUSH_TAIL :
                            (pick < 90) ? OP_POP_HEAD : OP_REVERSE;
                    2: op = (pick < 30) ? OP_PUSH_HEAD : (pick < 60) ? OP_PUSH_TAIL :
                            (pick < 90) ? OP_POP_HEAD : OP_REVERSE;
                    default: op = t_op'(pick % 4);
                endcase
                add_item(op, random_value());
            end
            left -= run;
        end
    endtask

    // Driver: offers the oldest pending item and predicts each one accepted.
    always @(posedge i_clk) begin : drive_proc
        t_result r;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && busy) begin
            // Hold the offered item until the block takes it.
        end else begin
            if (start) begin
                r = predict_response(i_request);
                expected_results.push_back(r);
                void'(pending_items.pop_front());
            end
            if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                start     <= 1'b1;
                i_request <= pending_items[0];
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: every strobed result is checked against the oldest prediction.
    always @(posedge i_clk) begin : check_proc
        t_result want;
        if (i_rst_n && o_done) begin
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("Mismatch: result with no item outstanding:",
                             " ok=%0b pop=%0d cnt=%0d",
                             o_result.ok, o_result.popped_value, o_result.entry_count);
                end
            end else begin
                want = expected_results.pop_front();
                results_checked++;
                if (o_result.ok !== want.ok || o_result.popped_value !== want.popped_value ||
                    o_result.entry_count !== want.entry_count) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("Mismatch at result %0d: expected ok=%0b pop=%0d cnt=%0d,",
                                 results_checked, want.ok, want.popped_value,
                                 want.entry_count,
                                 " got ok=%0b pop=%0d cnt=%0d",
                                 o_result.ok, o_result.popped_value,
                                 o_result.entry_count);
                    end
                end
            end
        end
    end

    // Stimulus in three phases of sender idling, then the verdict.
    initial begin : stimulus_proc
        int guard;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        sender_idle_pct = 32;
        queue_directed_items();
        queue_random_items(600);
        while (pending_items.size() != 0) @(negedge i_clk);

        sender_idle_pct = 66;
        queue_random_items(600);
        while (pending_items.size() != 0) @(negedge i_clk);

        sender_idle_pct = 0;
        queue_random_items(600);
        while (pending_items.size() != 0) @(negedge i_clk);

        // Let the last results arrive, then a few spare cycles.
        guard = 0;
        while (expected_results.size() != 0 && guard < 100) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (4) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            $display("Mismatch: %0d results never arrived", expected_results.size());
            mismatch_count += expected_results.size();
        end

        $display("Checked %0d results: %0d head inserts, %0d tail inserts,",
                 results_checked, op_count[0], op_count[1],
                 " %0d removes, %0d reverses.", op_count[2], op_count[3]);
        $display("Inserts refused on a full queue: %0d; removes refused on an empty one: %0d.",
                 full_rejects, empty_rejects);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog against a hung run.
    initial begin : watchdog_proc
        #4_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
